// ----- rtl/core/lcvr_pkg.sv -----
// ----------------------------------------------------------------------------
// lcvr_pkg
// Shared types, character codes and constants of the line command value
// receiver.
// ----------------------------------------------------------------------------
package lcvr_pkg;

    // Line framing
    localparam int unsigned LINE_LEN_W    = 6;
    localparam int unsigned MAX_LINE_LEN  = 32;
    localparam int unsigned MIN_MSG_LEN   = 2;

    // Fixed point scaling: value counts units of 10^-FRACTION_PLACES
    localparam logic [1:0]  FRACTION_PLACES = 2'd3;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned ACC_W   = 36;   // acc * 10 plus a digit weight

    localparam logic [VALUE_W-1:0] MAG_CAP   = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [TIME_W-1:0]  AGE_RESET = 32'd100;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE_CURRENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE_MISC    = 1'b1;

    // Character codes
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_VT      = 8'h0B;
    localparam logic [7:0] CHAR_FF      = 8'h0C;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_POINT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_I_UPPER = 8'h49;
    localparam logic [7:0] CHAR_I_LOWER = 8'h69;

    // Number parser phase
    typedef enum logic [1:0] {
        PH_BLANKS = 2'd0,
        PH_INT    = 2'd1,
        PH_FRAC   = 2'd2,
        PH_STOP   = 2'd3
    } phase_t;

    // Completed message from the parser
    typedef struct packed {
        logic               done;
        logic [7:0]         command;
        logic [VALUE_W-1:0] value;
    } msg_t;

    // Powers of ten for digit weights
    function automatic logic [9:0] pow_ten(input logic [1:0] k);
        logic [9:0] p;
        case (k)
            2'd0:    p = 10'd1;
            2'd1:    p = 10'd10;
            2'd2:    p = 10'd100;
            2'd3:    p = 10'd1000;
            default: p = 10'd1;
        endcase
        return p;
    endfunction

endpackage

// ----- rtl/core/lcvr_parser.sv -----
// ----------------------------------------------------------------------------
// lcvr_parser
// Line assembly and on-the-fly decimal parsing; flags a completed message.
// ----------------------------------------------------------------------------
module lcvr_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic               action,
    input  logic [7:0]         rx_byte,
    output lcvr_pkg::msg_t     msg
);

    logic [lcvr_pkg::LINE_LEN_W-1:0] len_reg, len_next;
    logic [7:0]                      cmd_reg, cmd_next;
    lcvr_pkg::phase_t                phase_reg, phase_next;
    logic                            neg_reg, neg_next;
    logic [lcvr_pkg::VALUE_W-1:0]    acc_reg, acc_next;
    logic [1:0]                      frac_reg, frac_next;

    logic                            is_digit;
    logic                            is_blank;
    logic                            is_sign;
    logic [3:0]                      digit;
    lcvr_pkg::phase_t                eff_phase;
    logic [13:0]                     int_weight;
    logic [13:0]                     frac_weight;
    logic [1:0]                      frac_idx;
    logic [lcvr_pkg::ACC_W-1:0]      int_sum;
    logic [lcvr_pkg::ACC_W-1:0]      frac_sum;
    logic [lcvr_pkg::VALUE_W-1:0]    int_sat;
    logic [lcvr_pkg::VALUE_W-1:0]    frac_sat;
    logic [lcvr_pkg::VALUE_W-1:0]    signed_val;
    logic [lcvr_pkg::LINE_LEN_W-1:0] len_inc;

    // Character classes
    assign is_digit = (rx_byte >= lcvr_pkg::CHAR_ZERO) && (rx_byte <= lcvr_pkg::CHAR_NINE);
    assign is_blank = (rx_byte == lcvr_pkg::CHAR_SPACE) || (rx_byte == lcvr_pkg::CHAR_TAB) ||
                      (rx_byte == lcvr_pkg::CHAR_VT)    || (rx_byte == lcvr_pkg::CHAR_FF);
    assign is_sign  = (rx_byte == lcvr_pkg::CHAR_PLUS) || (rx_byte == lcvr_pkg::CHAR_MINUS);
    assign digit    = 4'(rx_byte - lcvr_pkg::CHAR_ZERO);

    // A non-blank, non-sign byte in the blank phase is handled as integer part
    assign eff_phase = ((phase_reg == lcvr_pkg::PH_BLANKS) && !is_blank && !is_sign)
                       ? lcvr_pkg::PH_INT : phase_reg;

    // Digit weights and the two accumulate paths (acc * 10 + w, acc + w)
    assign frac_idx    = 2'(lcvr_pkg::FRACTION_PLACES - 2'd1 - frac_reg);
    assign int_weight  = 14'(digit) * 14'(lcvr_pkg::pow_ten(lcvr_pkg::FRACTION_PLACES));
    assign frac_weight = 14'(digit) * 14'(lcvr_pkg::pow_ten(frac_idx));
    assign int_sum  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} +
                      {22'd0, int_weight};
    assign frac_sum = {4'd0, acc_reg} + {22'd0, frac_weight};
    assign int_sat  = (int_sum > {4'd0, lcvr_pkg::MAG_CAP}) ? lcvr_pkg::MAG_CAP
                                                            : int_sum[lcvr_pkg::VALUE_W-1:0];
    assign frac_sat = (frac_sum > {4'd0, lcvr_pkg::MAG_CAP}) ? lcvr_pkg::MAG_CAP
                                                             : frac_sum[lcvr_pkg::VALUE_W-1:0];

    // Signed, saturated message value
    assign signed_val = neg_reg ? (32'd0 - acc_reg)
                                : (acc_reg[31] ? lcvr_pkg::POS_LIMIT : acc_reg);

    assign len_inc = len_reg + 1'b1;

    // Next line state
    always_comb begin
        len_next   = len_reg;
        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        frac_next  = frac_reg;
        msg        = '0;
        if (advance && !action) begin
            if (rx_byte == lcvr_pkg::CHAR_LF) begin
                if (len_reg >= lcvr_pkg::LINE_LEN_W'(lcvr_pkg::MIN_MSG_LEN)) begin
                    msg.done    = 1'b1;
                    msg.command = cmd_reg;
                    msg.value   = signed_val;
                end
                len_next   = '0;
                cmd_next   = '0;
                phase_next = lcvr_pkg::PH_BLANKS;
                neg_next   = 1'b0;
                acc_next   = '0;
                frac_next  = '0;
            end else if (rx_byte != lcvr_pkg::CHAR_CR) begin
                if (len_reg == '0) begin
                    cmd_next = rx_byte;
                end else begin
                    case (eff_phase)
                        lcvr_pkg::PH_BLANKS: begin
                            if (is_sign) begin
                                neg_next   = (rx_byte == lcvr_pkg::CHAR_MINUS);
                                phase_next = lcvr_pkg::PH_INT;
                            end
                        end
                        lcvr_pkg::PH_INT: begin
                            if (is_digit) begin
                                acc_next   = int_sat;
                                phase_next = lcvr_pkg::PH_INT;
                            end else if (rx_byte == lcvr_pkg::CHAR_POINT) begin
                                phase_next = lcvr_pkg::PH_FRAC;
                            end else begin
                                phase_next = lcvr_pkg::PH_STOP;
                            end
                        end
                        lcvr_pkg::PH_FRAC: begin
                            if (is_digit) begin
                                if (frac_reg < lcvr_pkg::FRACTION_PLACES) begin
                                    acc_next  = frac_sat;
                                    frac_next = frac_reg + 2'd1;
                                end
                            end else begin
                                phase_next = lcvr_pkg::PH_STOP;
                            end
                        end
                        default: ;
                    endcase
                end
                len_next = len_inc;
                // Overlong line: drop it and start fresh
                if (len_inc >= lcvr_pkg::LINE_LEN_W'(lcvr_pkg::MAX_LINE_LEN)) begin
                    len_next   = '0;
                    cmd_next   = '0;
                    phase_next = lcvr_pkg::PH_BLANKS;
                    neg_next   = 1'b0;
                    acc_next   = '0;
                    frac_next  = '0;
                end
            end
        end
    end

    // Line state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            cmd_reg   <= '0;
            phase_reg <= lcvr_pkg::PH_BLANKS;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            frac_reg  <= '0;
        end else begin
            len_reg   <= len_next;
            cmd_reg   <= cmd_next;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            frac_reg  <= frac_next;
        end
    end

endmodule

// ----- rtl/core/lcvr_status.sv -----
// ----------------------------------------------------------------------------
// lcvr_status
// Stored current and misc values with time stamps, age limits and staleness.
// ----------------------------------------------------------------------------
module lcvr_status (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lcvr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_wdata,
    input  logic                              advance,
    input  lcvr_pkg::msg_t                    msg,
    input  logic [lcvr_pkg::TIME_W-1:0]       now_ms,
    output logic [lcvr_pkg::VALUE_W-1:0]      current_milli,
    output logic [lcvr_pkg::VALUE_W-1:0]      misc_milli,
    output logic [7:0]                        misc_command,
    output logic                              current_stale,
    output logic                              misc_stale
);

    logic [lcvr_pkg::TIME_W-1:0]  age_cur_reg, age_misc_reg;
    logic [lcvr_pkg::VALUE_W-1:0] cur_val_reg, cur_val_next;
    logic [lcvr_pkg::VALUE_W-1:0] misc_val_reg, misc_val_next;
    logic [7:0]                   misc_cmd_reg, misc_cmd_next;
    logic [lcvr_pkg::TIME_W-1:0]  cur_stamp_reg, cur_stamp_next;
    logic [lcvr_pkg::TIME_W-1:0]  misc_stamp_reg, misc_stamp_next;
    logic                         is_current;
    logic [lcvr_pkg::TIME_W-1:0]  cur_age;
    logic [lcvr_pkg::TIME_W-1:0]  misc_age;

    assign is_current = (msg.command == lcvr_pkg::CHAR_I_UPPER) ||
                        (msg.command == lcvr_pkg::CHAR_I_LOWER);

    // Store update on a completed message
    always_comb begin
        cur_val_next    = cur_val_reg;
        cur_stamp_next  = cur_stamp_reg;
        misc_val_next   = misc_val_reg;
        misc_cmd_next   = misc_cmd_reg;
        misc_stamp_next = misc_stamp_reg;
        if (advance && msg.done) begin
            if (is_current) begin
                cur_val_next   = msg.value;
                cur_stamp_next = now_ms;
            end else begin
                misc_val_next   = msg.value;
                misc_cmd_next   = msg.command;
                misc_stamp_next = now_ms;
            end
        end
    end

    // Staleness on the updated stamps; a zero stamp means never received
    assign cur_age       = now_ms - cur_stamp_next;
    assign misc_age      = now_ms - misc_stamp_next;
    assign current_stale = (cur_stamp_next == '0) || (cur_age > age_cur_reg);
    assign misc_stale    = (misc_stamp_next == '0) || (misc_age > age_misc_reg);

    assign current_milli = cur_val_next;
    assign misc_milli    = misc_val_next;
    assign misc_command  = misc_cmd_next;

    // Age limit registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            age_cur_reg  <= lcvr_pkg::AGE_RESET;
            age_misc_reg <= lcvr_pkg::AGE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lcvr_pkg::REG_MAX_AGE_CURRENT: age_cur_reg  <= cfg_wdata;
                lcvr_pkg::REG_MAX_AGE_MISC:    age_misc_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stored values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_val_reg    <= '0;
            cur_stamp_reg  <= '0;
            misc_val_reg   <= '0;
            misc_cmd_reg   <= '0;
            misc_stamp_reg <= '0;
        end else begin
            cur_val_reg    <= cur_val_next;
            cur_stamp_reg  <= cur_stamp_next;
            misc_val_reg   <= misc_val_next;
            misc_cmd_reg   <= misc_cmd_next;
            misc_stamp_reg <= misc_stamp_next;
        end
    end

endmodule

// ----- rtl/core/line_command_value_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// line_command_value_receiver_unit
// Parses received text lines "<letter><decimal>" into signed thousandths and
// keeps the last current and misc values with staleness flags.
//
//   Channel   Ports                                   Handshake
//   input     s_action, s_rx_byte, s_now_ms           s_valid / s_ready
//   result    m_msg_done .. m_misc_stale              m_valid / m_ready
//   config    cfg_wr_en, cfg_index, cfg_wdata         write enable only
//
// One item per cycle sustained unless the result stalls; an input transfer
// passes the input register, then one pass of parse and store logic into
// the result register. Reset is synchronous on aresetn and clears line state,
// stored values, stamps and sets both age limits to 100 ms. A stalled result
// holds the result register; the input register still takes one more item.
// ----------------------------------------------------------------------------
module line_command_value_receiver_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic [7:0]                        s_rx_byte,
    input  logic [lcvr_pkg::TIME_W-1:0]       s_now_ms,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_msg_done,
    output logic [7:0]                        m_msg_command,
    output logic signed [lcvr_pkg::VALUE_W-1:0] m_msg_value_milli,
    output logic signed [lcvr_pkg::VALUE_W-1:0] m_current_milli,
    output logic signed [lcvr_pkg::VALUE_W-1:0] m_misc_milli,
    output logic [7:0]                        m_misc_command,
    output logic                              m_current_stale,
    output logic                              m_misc_stale,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [lcvr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_wdata
);

    logic                         in_valid_reg;
    logic                         in_action_reg;
    logic [7:0]                   in_byte_reg;
    logic [lcvr_pkg::TIME_W-1:0]  in_now_reg;
    logic                         out_valid_reg, out_valid_next;
    logic                         advance;

    lcvr_pkg::msg_t               msg;
    logic [lcvr_pkg::VALUE_W-1:0] cur_milli;
    logic [lcvr_pkg::VALUE_W-1:0] misc_milli;
    logic [7:0]                   misc_cmd;
    logic                         cur_stale;
    logic                         misc_stale;

    logic                         done_reg;
    logic [7:0]                   cmd_reg;
    logic [lcvr_pkg::VALUE_W-1:0] val_reg;
    logic [lcvr_pkg::VALUE_W-1:0] cur_milli_reg;
    logic [lcvr_pkg::VALUE_W-1:0] misc_milli_reg;
    logic [7:0]                   misc_cmd_reg;
    logic                         cur_stale_reg;
    logic                         misc_stale_reg;

    // Pipeline flow: the held item moves into the result register when free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= s_action;
            in_byte_reg   <= s_rx_byte;
            in_now_reg    <= s_now_ms;
        end
    end

    lcvr_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .action  (in_action_reg),
        .rx_byte (in_byte_reg),
        .msg     (msg)
    );

    lcvr_status u_status (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .advance       (advance),
        .msg           (msg),
        .now_ms        (in_now_reg),
        .current_milli (cur_milli),
        .misc_milli    (misc_milli),
        .misc_command  (misc_cmd),
        .current_stale (cur_stale),
        .misc_stale    (misc_stale)
    );

    // Result valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (advance) begin
            done_reg       <= msg.done;
            cmd_reg        <= msg.command;
            val_reg        <= msg.value;
            cur_milli_reg  <= cur_milli;
            misc_milli_reg <= misc_milli;
            misc_cmd_reg   <= misc_cmd;
            cur_stale_reg  <= cur_stale;
            misc_stale_reg <= misc_stale;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_msg_done        = done_reg;
    assign m_msg_command     = cmd_reg;
    assign m_msg_value_milli = val_reg;
    assign m_current_milli   = cur_milli_reg;
    assign m_misc_milli      = misc_milli_reg;
    assign m_misc_command    = misc_cmd_reg;
    assign m_current_stale   = cur_stale_reg;
    assign m_misc_stale      = misc_stale_reg;

endmodule
